### rtl/core/afltl_pkg.sv
// Shared types and constants for the animation frame timeline lookup block.
// Holds the request codes, result status codes, register indexes and the frame record.
// No dependencies.
package afltl_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 64;
  localparam int unsigned IDX_OUT_W      = 6;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_OFFSET_X    = 2'd0,
    CFG_OFFSET_Y    = 2'd1,
    CFG_BASE_SPRITE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SEARCH,
    S_LOAD,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [8:0]         width;
    logic [7:0]         height;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
  } frame_rec_t;

  localparam logic signed [10:0] OFFSET_X_RST    = -11'sd4;
  localparam logic signed [10:0] OFFSET_Y_RST    = -11'sd8;
  localparam logic [15:0]        BASE_SPRITE_RST = 16'd0;

endpackage

### rtl/core/afltl_intf.sv
// Channel interfaces of the animation frame timeline lookup block.
// Request, result and register write channels, each with valid and ready.
// No dependencies.
interface afltl_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [8:0]         frame_width;
  logic [7:0]         frame_height;
  logic signed [15:0] pivot_x;
  logic signed [15:0] pivot_y;
  logic [15:0]        duration;
  logic [31:0]        query_ticks;

  modport source (output valid, action, frame_width, frame_height, pivot_x, pivot_y,
                  duration, query_ticks, input ready);
  modport sink (input valid, action, frame_width, frame_height, pivot_x, pivot_y,
                duration, query_ticks, output ready);
endinterface

interface afltl_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         frame_index;
  logic [15:0]        sprite_number;
  logic signed [16:0] screen_x;
  logic signed [16:0] screen_y;
  logic [15:0]        total_ticks;

  modport source (output valid, status, frame_index, sprite_number, screen_x, screen_y,
                  total_ticks, input ready);
  modport sink (input valid, status, frame_index, sprite_number, screen_x, screen_y,
                total_ticks, output ready);
endinterface

interface afltl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/afltl_cum_cell.sv
// One cumulative end tick of the frame table with its own compare against the query tick.
// Depends on nothing; instantiated once per frame slot by the top level.
module afltl_cum_cell (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [15:0] cum_i,
  input  logic [31:0] tick_i,
  output logic        lt_o
);

  logic [15:0] cum_q;
  logic        lt_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cum_q <= cum_i;
    end
    lt_q <= (tick_i < {16'd0, cum_q});
  end

  assign lt_o = lt_q;

endmodule

### rtl/core/afltl_step_cell.sv
// One halving step of the frame search; a row of these narrows lo and hi.
// Depends on afltl_pkg for the default table depth.
module afltl_step_cell #(
  parameter int unsigned MAX_FRAMES = afltl_pkg::MAX_FRAMES_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_FRAMES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [IDX_W-1:0]      lo_i,
  input  logic [IDX_W-1:0]      hi_i,
  input  logic [MAX_FRAMES-1:0] lt_i,
  output logic                  vld_o,
  output logic [IDX_W-1:0]      lo_o,
  output logic [IDX_W-1:0]      hi_o
);

  logic             vld_q;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] mid;

  always_comb begin
    sum  = {1'b0, lo_i} + {1'b0, hi_i};
    mid  = sum[IDX_W:1];
    lo_d = lo_i;
    hi_d = hi_i;
    // Once the range has closed the step passes lo and hi on untouched.
    if (lo_i < hi_i) begin
      if (lt_i[mid]) begin
        hi_d = mid;
      end else begin
        lo_d = mid + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign vld_o = vld_q;
  assign lo_o  = lo_q;
  assign hi_o  = hi_q;

endmodule

### rtl/core/afltl_frame_mem.sv
// Frame record store: one write port for appends, one registered read port for lookups.
// Depends on afltl_pkg for the frame record type.
module afltl_frame_mem #(
  parameter int unsigned MAX_FRAMES = afltl_pkg::MAX_FRAMES_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_FRAMES)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [IDX_W-1:0]       waddr_i,
  input  afltl_pkg::frame_rec_t  wdata_i,
  input  logic [IDX_W-1:0]       raddr_i,
  output afltl_pkg::frame_rec_t  rdata_o
);
  import afltl_pkg::*;

  frame_rec_t mem [MAX_FRAMES];
  frame_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/animation_frame_timeline_lookup_top.sv
// Sprite animation frame table with tick-to-frame lookup.
// Request channel req_i carries append, query and clear requests; every append,
// query and clear gives one result on rsp_o, a request with the unused action code
// gives none. Registers offset_x, offset_y and base_sprite are written on cfg_i,
// which is always ready.
// Append, clear, full-table and empty-table requests pass their result through the
// result descriptor registers into the output register; then the next request can be
// taken. A query compares the tick against every stored end tick at once, then runs
// through a row of clog2(MAX_FRAMES) search cells and a registered read of the frame
// store, and its result passes through the result descriptor registers into the
// output register. One request is worked on at a time; the next is taken once the
// previous result sits in the output register, even while the receiver stalls it
// there.
// Reset empties the table (frame count and tick total to zero) and loads the
// register reset values; the frame store itself is not cleared.
module animation_frame_timeline_lookup_top #(
  parameter int unsigned MAX_FRAMES = afltl_pkg::MAX_FRAMES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  afltl_req_if.sink    req_i,
  afltl_rsp_if.source  rsp_o,
  afltl_cfg_if.sink    cfg_i
);
  import afltl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned NSTEP = IDX_W;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cnt_m1;
  logic [15:0]      total_q, total_d;
  logic [15:0]      app_total;
  logic [31:0]      t_q, t_d;

  logic signed [10:0] off_x_q;
  logic signed [10:0] off_y_q;
  logic [15:0]        base_q;

  logic             head_vld_q, head_vld_d;
  logic [IDX_W-1:0] head_lo_q, head_lo_d;
  logic [IDX_W-1:0] head_hi_q, head_hi_d;

  logic [MAX_FRAMES-1:0] lt;
  logic                  chain_vld [NSTEP+1];
  logic [IDX_W-1:0]      chain_lo  [NSTEP+1];
  logic [IDX_W-1:0]      chain_hi  [NSTEP+1];

  logic             mem_we;
  logic [IDX_W-1:0] slot;
  frame_rec_t       in_rec;
  frame_rec_t       mem_rdata;

  status_e          desc_status_q, desc_status_d;
  logic             desc_zero_q, desc_zero_d;
  logic [IDX_W-1:0] desc_slot_q, desc_slot_d;
  frame_rec_t       desc_rec_q, desc_rec_d;

  logic                         req_fire;
  logic                         load_out;
  logic                         out_vld_q, out_vld_d;
  logic [IDX_W+IDX_OUT_W-1:0]   slot_ext;
  logic [IDX_OUT_W-1:0]         idx6;
  logic signed [16:0]           sx, sy;
  logic [15:0]                  sprite;

  status_e            out_status_q;
  logic [5:0]         out_index_q;
  logic [15:0]        out_sprite_q;
  logic signed [16:0] out_sx_q;
  logic signed [16:0] out_sy_q;
  logic [15:0]        out_total_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign slot      = count_q[IDX_W-1:0];
  assign cnt_m1    = count_q - CNT_W'(1);
  assign app_total = total_q + req_i.duration;

  assign in_rec.width   = req_i.frame_width;
  assign in_rec.height  = req_i.frame_height;
  assign in_rec.pivot_x = req_i.pivot_x;
  assign in_rec.pivot_y = req_i.pivot_y;

  // Control sequencer.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    total_d       = total_q;
    t_d           = t_q;
    head_vld_d    = 1'b0;
    head_lo_d     = head_lo_q;
    head_hi_d     = head_hi_q;
    desc_status_d = desc_status_q;
    desc_zero_d   = desc_zero_q;
    desc_slot_d   = desc_slot_q;
    desc_rec_d    = desc_rec_q;
    mem_we        = 1'b0;
    load_out      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          unique case (action_e'(req_i.action))
            ACT_APPEND: begin
              if (count_q == CNT_W'(MAX_FRAMES)) begin
                desc_status_d = ST_FULL;
                desc_zero_d   = 1'b1;
              end else begin
                mem_we        = 1'b1;
                total_d       = app_total;
                count_d       = count_q + CNT_W'(1);
                desc_status_d = ST_OK;
                desc_zero_d   = 1'b0;
                desc_slot_d   = slot;
                desc_rec_d    = in_rec;
              end
              state_d = S_RESULT;
            end
            ACT_QUERY: begin
              if (count_q == '0) begin
                desc_status_d = ST_EMPTY;
                desc_zero_d   = 1'b1;
                state_d       = S_RESULT;
              end else begin
                t_d     = req_i.query_ticks;
                state_d = S_CMP;
              end
            end
            ACT_CLEAR: begin
              count_d       = '0;
              total_d       = '0;
              desc_status_d = ST_OK;
              desc_zero_d   = 1'b1;
              state_d       = S_RESULT;
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        // The compare bits settle at this edge; a tick at or past the total
        // starts the search already closed on the last frame.
        head_vld_d = 1'b1;
        head_hi_d  = cnt_m1[IDX_W-1:0];
        head_lo_d  = (t_q >= {16'd0, total_q}) ? cnt_m1[IDX_W-1:0] : '0;
        state_d    = S_SEARCH;
      end
      S_SEARCH: begin
        if (chain_vld[NSTEP]) begin
          desc_slot_d = chain_lo[NSTEP];
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        desc_rec_d    = mem_rdata;
        desc_status_d = ST_OK;
        desc_zero_d   = 1'b0;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (!out_vld_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      total_q    <= '0;
      head_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      total_q    <= total_d;
      head_vld_q <= head_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= OFFSET_X_RST;
      off_y_q <= OFFSET_Y_RST;
      base_q  <= BASE_SPRITE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_OFFSET_X:    off_x_q <= cfg_i.data[10:0];
        CFG_OFFSET_Y:    off_y_q <= cfg_i.data[10:0];
        CFG_BASE_SPRITE: base_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    t_q           <= t_d;
    head_lo_q     <= head_lo_d;
    head_hi_q     <= head_hi_d;
    desc_status_q <= desc_status_d;
    desc_zero_q   <= desc_zero_d;
    desc_slot_q   <= desc_slot_d;
    desc_rec_q    <= desc_rec_d;
  end

  // End tick cells, one per slot.
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cum
    afltl_cum_cell u_cum (
      .clk_i  (clk_i),
      .we_i   (mem_we && (slot == IDX_W'(i))),
      .cum_i  (app_total),
      .tick_i (t_q),
      .lt_o   (lt[i])
    );
  end

  // Search cell row.
  assign chain_vld[0] = head_vld_q;
  assign chain_lo[0]  = head_lo_q;
  assign chain_hi[0]  = head_hi_q;

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    afltl_step_cell #(
      .MAX_FRAMES (MAX_FRAMES)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (chain_vld[s]),
      .lo_i   (chain_lo[s]),
      .hi_i   (chain_hi[s]),
      .lt_i   (lt),
      .vld_o  (chain_vld[s+1]),
      .lo_o   (chain_lo[s+1]),
      .hi_o   (chain_hi[s+1])
    );
  end

  afltl_frame_mem #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot),
    .wdata_i (in_rec),
    .raddr_i (chain_lo[NSTEP]),
    .rdata_o (mem_rdata)
  );

  // Result formatting.
  assign slot_ext = {{IDX_OUT_W{1'b0}}, desc_slot_q};
  assign idx6     = slot_ext[IDX_OUT_W-1:0];
  assign sprite   = base_q + {10'd0, idx6};
  assign sx = $signed({desc_rec_q.pivot_x[15], desc_rec_q.pivot_x})
            + $signed({9'd0, desc_rec_q.width[8:1]})
            + $signed({{6{off_x_q[10]}}, off_x_q});
  assign sy = $signed({desc_rec_q.pivot_y[15], desc_rec_q.pivot_y})
            + $signed({10'd0, desc_rec_q.height[7:1]})
            + $signed({{6{off_y_q[10]}}, off_y_q});

  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= desc_status_q;
      out_total_q  <= total_q;
      if (desc_zero_q) begin
        out_index_q  <= '0;
        out_sprite_q <= '0;
        out_sx_q     <= '0;
        out_sy_q     <= '0;
      end else begin
        out_index_q  <= idx6;
        out_sprite_q <= sprite;
        out_sx_q     <= sx;
        out_sy_q     <= sy;
      end
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.frame_index   = out_index_q;
  assign rsp_o.sprite_number = out_sprite_q;
  assign rsp_o.screen_x      = out_sx_q;
  assign rsp_o.screen_y      = out_sy_q;
  assign rsp_o.total_ticks   = out_total_q;

endmodule

### verif/tb_top.sv
// Testbench for the animation frame timeline lookup block: frame appends, tick queries,
// clears and register writes, checked against an in-bench model of the frame table.
// Depends on afltl_pkg, the channel interfaces and animation_frame_timeline_lookup_top.
module tb_top;
  import afltl_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [8:0]         frame_width;
    logic [7:0]         frame_height;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic [15:0]        duration;
    logic [31:0]        query_ticks;
  } frame_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         frame_index;
    logic [15:0]        sprite_number;
    logic signed [16:0] screen_x;
    logic signed [16:0] screen_y;
    logic [15:0]        total_ticks;
  } frame_rsp_t;

  // Mirror of the frame table; turns each accepted append, query and clear into the result it must give.
  class frame_table_scoreboard;
    logic [8:0]         width_mem   [MAX_FRAMES_DEF];
    logic [7:0]         height_mem  [MAX_FRAMES_DEF];
    logic signed [15:0] pivot_x_mem [MAX_FRAMES_DEF];
    logic signed [15:0] pivot_y_mem [MAX_FRAMES_DEF];
    logic [15:0]        cum_mem     [MAX_FRAMES_DEF];
    int unsigned        frame_count;
    logic [15:0]        tick_total;
    logic signed [10:0] offset_x;
    logic signed [10:0] offset_y;
    logic [15:0]        base_sprite;
    frame_rsp_t         pending_q[$];
    int unsigned        mismatches;

    function void reset_state();
      frame_count = 0;
      tick_total  = '0;
      offset_x    = OFFSET_X_RST;
      offset_y    = OFFSET_Y_RST;
      base_sprite = BASE_SPRITE_RST;
      pending_q.delete();
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_OFFSET_X:    offset_x = data[10:0];
        CFG_OFFSET_Y:    offset_y = data[10:0];
        CFG_BASE_SPRITE: base_sprite = data;
        default: ;
      endcase
    endfunction

    function frame_rsp_t describe_slot(int unsigned slot);
      frame_rsp_t r;
      int         sx;
      int         sy;
      // Keep the unsigned half-size out of the signed sums so the offsets sign-extend.
      sx = int'(pivot_x_mem[slot]);
      sx += int'(offset_x);
      sx += int'(width_mem[slot] >> 1);
      sy = int'(pivot_y_mem[slot]);
      sy += int'(offset_y);
      sy += int'(height_mem[slot] >> 1);
      r = '0;
      r.status        = ST_OK;
      r.frame_index   = slot[5:0];
      r.sprite_number = base_sprite + {10'd0, slot[5:0]};
      r.screen_x      = sx[16:0];
      r.screen_y      = sy[16:0];
      return r;
    endfunction

    function void note_request(frame_req_t q);
      frame_rsp_t  r;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      r = '0;
      case (q.action)
        ACT_APPEND: begin
          if (frame_count >= MAX_FRAMES_DEF) begin
            r.status = ST_FULL;
          end else begin
            width_mem[frame_count]   = q.frame_width;
            height_mem[frame_count]  = q.frame_height;
            pivot_x_mem[frame_count] = q.pivot_x;
            pivot_y_mem[frame_count] = q.pivot_y;
            tick_total               = tick_total + q.duration;
            cum_mem[frame_count]     = tick_total;
            r = describe_slot(frame_count);
            frame_count++;
          end
        end
        ACT_QUERY: begin
          if (frame_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            lo = 0;
            hi = frame_count - 1;
            if (q.query_ticks >= {16'd0, tick_total}) begin
              lo = hi;
            end else begin
              // Runs on whatever the table holds, even when a wrapped total broke the order.
              while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (q.query_ticks < {16'd0, cum_mem[mid]}) hi = mid;
                else lo = mid + 1;
              end
            end
            r = describe_slot(lo);
          end
        end
        ACT_CLEAR: begin
          frame_count = 0;
          tick_total  = '0;
        end
        default: return;
      endcase
      r.total_ticks = tick_total;
      pending_q.push_back(r);
    endfunction

    function void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
        mismatches++;
      end
    endfunction

    function void check_result(frame_rsp_t got);
      frame_rsp_t exp_rsp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d frame %0d",
                 $time, got.status, got.frame_index);
        mismatches++;
        return;
      end
      exp_rsp = pending_q.pop_front();
      compare_field("status", int'(exp_rsp.status), int'(got.status));
      compare_field("frame_index", int'(exp_rsp.frame_index), int'(got.frame_index));
      compare_field("sprite_number", int'(exp_rsp.sprite_number),
                    int'(got.sprite_number));
      compare_field("screen_x", int'(exp_rsp.screen_x), int'(got.screen_x));
      compare_field("screen_y", int'(exp_rsp.screen_y), int'(got.screen_y));
      compare_field("total_ticks", int'(exp_rsp.total_ticks), int'(got.total_ticks));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  afltl_req_if req_if ();
  afltl_rsp_if rsp_if ();
  afltl_cfg_if cfg_if ();

  animation_frame_timeline_lookup_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  frame_table_scoreboard sb;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  logic                  hold_rsp;
  int unsigned           items_sent;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin : rsp_monitor
    frame_rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.status        = rsp_if.status;
      got.frame_index   = rsp_if.frame_index;
      got.sprite_number = rsp_if.sprite_number;
      got.screen_x      = rsp_if.screen_x;
      got.screen_y      = rsp_if.screen_y;
      got.total_ticks   = rsp_if.total_ticks;
      sb.check_result(got);
    end
    rsp_if.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic frame_req_t make_request(logic [1:0] act);
    frame_req_t r;
    r.action       = act;
    r.frame_width  = 9'($urandom);
    r.frame_height = 8'($urandom);
    r.pivot_x      = 16'($urandom);
    r.pivot_y      = 16'($urandom);
    r.duration     = 16'($urandom);
    r.query_ticks  = $urandom;
    return r;
  endfunction

  function automatic logic [15:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  // Ticks near stored end ticks and the total hit the search boundaries.
  function automatic logic [31:0] pick_tick();
    int unsigned k;
    logic [31:0] end_tick;
    logic [31:0] total;
    if (sb.frame_count == 0) return $urandom;
    k        = $urandom_range(0, sb.frame_count - 1);
    end_tick = {16'd0, sb.cum_mem[k]};
    total    = {16'd0, sb.tick_total};
    case ($urandom_range(0, 7))
      0:       return end_tick - 1;
      1:       return end_tick;
      2:       return end_tick + 1;
      3:       return total;
      4:       return total - 1;
      5:       return $urandom_range(0, sb.tick_total);
      6:       return $urandom;
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  task automatic send_request(frame_req_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= q.action;
    req_if.frame_width  <= q.frame_width;
    req_if.frame_height <= q.frame_height;
    req_if.pivot_x      <= q.pivot_x;
    req_if.pivot_y      <= q.pivot_y;
    req_if.duration     <= q.duration;
    req_if.query_ticks  <= q.query_ticks;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(q);
    if (q.action != ACT_UNUSED) items_sent++;
  endtask

  task automatic append_frame(logic [8:0] w, logic [7:0] h, logic [15:0] px,
                              logic [15:0] py, logic [15:0] dur);
    frame_req_t r;
    r              = make_request(ACT_APPEND);
    r.frame_width  = w;
    r.frame_height = h;
    r.pivot_x      = px;
    r.pivot_y      = py;
    r.duration     = dur;
    send_request(r);
  endtask

  task automatic query_at(logic [31:0] t);
    frame_req_t r;
    r             = make_request(ACT_QUERY);
    r.query_ticks = t;
    send_request(r);
  endtask

  task automatic write_config(logic [15:0] x, logic [15:0] y, logic [15:0] base);
    cfg_idx_e    idx;
    logic [15:0] data;
    for (int i = 0; i < 3; i++) begin
      idx  = cfg_idx_e'(i);
      data = (i == 0) ? x : (i == 1) ? y : base;
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= data;
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(idx, data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Drops valid and waits until every expected result has been checked.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_timeline(int unsigned frames);
    frame_req_t r;
    send_request(make_request(ACT_CLEAR));
    for (int unsigned i = 0; i < frames; i++) begin
      if ($urandom_range(0, 11) == 0) send_request(make_request(2'($urandom_range(0, 3))));
      r          = make_request(ACT_APPEND);
      r.duration = pick_duration();
      send_request(r);
    end
    repeat ($urandom_range(2, 10)) query_at(pick_tick());
  endtask

  initial begin
    frame_req_t  r;
    int unsigned start;
    sb = new;
    sb.reset_state();
    send_idle_pct       = 15;
    recv_idle_pct       = 61;
    hold_rsp            = 1'b0;
    items_sent          = 0;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.action       = ACT_APPEND;
    req_if.frame_width  = '0;
    req_if.frame_height = '0;
    req_if.pivot_x      = '0;
    req_if.pivot_y      = '0;
    req_if.duration     = '0;
    req_if.query_ticks  = '0;
    rsp_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_OFFSET_X;
    cfg_if.data         = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values.
    query_at(32'd0);
    query_at(32'hFFFF_FFFF);
    send_request(make_request(ACT_CLEAR));
    send_request(make_request(ACT_UNUSED));
    append_frame(9'd511, 8'd255, 16'h8000, 16'h8000, 16'hFFFF);
    append_frame(9'd0, 8'd0, 16'h7FFF, 16'h7FFF, 16'd0);
    append_frame(9'd1, 8'd1, 16'h0000, 16'h0000, 16'd1);  // running total wraps to zero
    query_at(32'd0);
    query_at(32'hFFFF_FFFF);
    append_frame(9'd510, 8'd254, 16'hFFFF, 16'h0001, 16'd100);
    query_at(32'd50);
    query_at(32'd99);
    query_at(32'd100);
    send_request(make_request(ACT_CLEAR));
    for (int i = 1; i <= 3; i++) begin
      r          = make_request(ACT_APPEND);
      r.duration = 16'(10 * i);
      send_request(r);
    end
    query_at(32'd0);
    query_at(32'd9);
    query_at(32'd10);
    query_at(32'd30);
    query_at(32'd59);
    query_at(32'd60);
    query_at(32'h0001_0005);
    query_at(32'hFFFF_FFFF);

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      send_idle_pct = (phase < 2) ? 15 : (phase < 4) ? 61 : 0;
      recv_idle_pct = (phase < 2) ? 61 : (phase < 4) ? 15 : 0;
      case (phase)
        0:       write_config(16'hFC00, 16'h03FF, 16'hFFFF);
        1:       write_config(16'h03FF, 16'hFC00, 16'h0000);
        5:       write_config(16'hFFFF, 16'h0001, 16'h8000);
        default: write_config(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (phase == 4) begin
        // Long receiver stall while requests keep coming, so the block backs up.
        fork
          begin
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clk);
            hold_rsp <= 1'b0;
          end
        join_none
      end
      start = items_sent;
      if (phase == 0 || phase == 3) run_timeline(66);
      while (items_sent - start < 70) begin
        if ($urandom_range(0, 7) == 0) run_timeline($urandom_range(60, 66));
        else run_timeline($urandom_range(1, 12));
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### animation_frame_timeline_lookup_top.f
rtl/core/afltl_pkg.sv
rtl/core/afltl_intf.sv
rtl/core/afltl_cum_cell.sv
rtl/core/afltl_step_cell.sv
rtl/core/afltl_frame_mem.sv
rtl/core/animation_frame_timeline_lookup_top.sv
verif/tb_top.sv
